// ===== hdl/hfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the HDLC frame receiver.
// No dependencies; every other file in this block imports it.
package hfr_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  ESC_XOR  = 8'h20;

	typedef enum logic [2:0] {
		RX_HUNT    = 3'd0,
		RX_RESTART = 3'd1,
		RX_HEADER  = 3'd2,
		RX_DATA    = 3'd3,
		RX_WAIT    = 3'd4
	} rx_phase_t;

	typedef enum logic [2:0] {
		LK_IDLE   = 3'd0,
		LK_DATA   = 3'd1,
		LK_ESCAPE = 3'd2,
		LK_CRC    = 3'd3,
		LK_PAD    = 3'd4
	} link_phase_t;

	typedef enum logic [2:0] {
		EV_HEADER   = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_CRC_OK   = 3'd2,
		EV_CRC_FAIL = 3'd3,
		EV_RAW_END  = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		CFG_FLAG       = 3'd0,
		CFG_ESCAPE     = 3'd1,
		CFG_MSG_ID     = 3'd2,
		CFG_RAW_ID     = 3'd3,
		CFG_RAW_MAX    = 3'd4,
		CFG_LEN_OFFSET = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] flag_value;
		logic [7:0] escape_value;
		logic [7:0] message_protocol_id;
		logic [7:0] raw_protocol_id;
		logic [7:0] raw_max_length;
		logic [2:0] length_field_offset;
	} cfg_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  value;
		logic [7:0]  position;
		logic [7:0]  payload_count;
		logic [15:0] crc_from_line;
		logic [15:0] crc_worked_out;
	} result_t;

	// CRC-16, poly 0x1021, MSB first: one byte per call
	function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/hfr_front.sv =====
// Front end: deframing state machine, unescaping, CRC and result classification.
// Depends on hfr_pkg.
module hfr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  hfr_pkg::cfg_t   cfg,
	input  logic            byte_valid,
	input  logic [7:0]      rx_byte,
	output logic            res_valid,
	output hfr_pkg::result_t res
);
	import hfr_pkg::*;

	rx_phase_t   rx_q, rx_d;
	link_phase_t link_q, link_d, pbe_q, pbe_d;
	logic [7:0]  proto_q, proto_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  exp_q, exp_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [15:0] crc_q, crc_d;

	logic        flag_hit, esc_hit, in_esc, pos_is_len, below_exp;
	logic [7:0]  b_un;
	link_phase_t link_after;
	logic [15:0] crc_next, crc_start;
	logic [8:0]  cnt_inc;

	assign flag_hit   = (rx_byte == cfg.flag_value);
	assign esc_hit    = (rx_byte == cfg.escape_value);
	assign in_esc     = (link_q == LK_ESCAPE);
	assign b_un       = in_esc ? (rx_byte ^ ESC_XOR) : rx_byte;
	assign link_after = in_esc ? pbe_q : link_q;
	assign crc_next   = crc16_add(crc_q, b_un);
	assign crc_start  = crc16_add(16'h0000, rx_byte);
	assign cnt_inc    = {1'b0, cnt_q} + 9'd1;
	assign pos_is_len = (cnt_q == {5'b0, cfg.length_field_offset});
	assign below_exp  = (cnt_q < exp_q);

	// next state
	always_comb begin
		rx_d    = rx_q;
		link_d  = link_q;
		pbe_d   = pbe_q;
		proto_d = proto_q;
		cnt_d   = cnt_q;
		exp_d   = exp_q;
		rcrc_d  = rcrc_q;
		crc_d   = crc_q;
		case (rx_q)
			RX_HUNT: begin
				if (flag_hit) rx_d = RX_RESTART;
			end
			RX_HEADER: begin
				if (esc_hit) begin
					pbe_d  = link_q;
					link_d = LK_ESCAPE;
				end else begin
					link_d = link_after;
					if (pos_is_len) exp_d = b_un;
					crc_d = crc_next;
					if (cnt_inc >= 9'(HEADER_BYTES)) begin
						cnt_d = 8'd0;
						rx_d  = RX_DATA;
					end else begin
						cnt_d = cnt_inc[7:0];
					end
				end
			end
			RX_DATA: begin
				if (flag_hit) begin
					rx_d   = RX_WAIT;
					link_d = LK_IDLE;
				end else if (esc_hit) begin
					pbe_d  = link_q;
					link_d = LK_ESCAPE;
				end else begin
					link_d = link_after;
					case (link_after)
						LK_DATA: begin
							if (below_exp) begin
								crc_d = crc_next;
								cnt_d = cnt_inc[7:0];
							end else begin
								rcrc_d = {8'h00, b_un};
								link_d = LK_CRC;
							end
						end
						LK_CRC: begin
							rcrc_d = {b_un, rcrc_q[7:0]};
							link_d = LK_PAD;
						end
						default: begin
							rx_d   = RX_HUNT;
							link_d = LK_IDLE;
						end
					endcase
				end
			end
			default: begin
				// wait or restart: look for the protocol byte
				if (flag_hit) begin
					rx_d = RX_RESTART;
				end else begin
					cnt_d   = 8'd0;
					link_d  = LK_DATA;
					proto_d = rx_byte;
					rcrc_d  = 16'h0000;
					crc_d   = crc_start;
					if (rx_byte == cfg.message_protocol_id) begin
						rx_d  = RX_HEADER;
						exp_d = 8'd0;
					end else if (rx_byte == cfg.raw_protocol_id) begin
						rx_d  = RX_DATA;
						exp_d = cfg.raw_max_length;
					end else begin
						rx_d = RX_WAIT;
					end
				end
			end
		endcase
	end

	// result for this word
	always_comb begin
		res_valid = 1'b0;
		res       = '{event_res: EV_HEADER, default: '0};
		case (rx_q)
			RX_HEADER: begin
				if (!esc_hit) begin
					res_valid    = byte_valid;
					res.value    = b_un;
					res.position = cnt_q;
				end
			end
			RX_DATA: begin
				if (flag_hit) begin
					res_valid = byte_valid;
					if (proto_q == cfg.message_protocol_id) begin
						res.event_res = (link_q == LK_PAD && crc_q == rcrc_q) ?
							EV_CRC_OK : EV_CRC_FAIL;
					end else begin
						res.event_res = EV_RAW_END;
					end
					res.payload_count  = cnt_q;
					res.crc_from_line  = rcrc_q;
					res.crc_worked_out = crc_q;
				end else if (!esc_hit && link_after == LK_DATA && below_exp) begin
					res_valid     = byte_valid;
					res.event_res = EV_PAYLOAD;
					res.value     = b_un;
					res.position  = cnt_q;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q    <= RX_WAIT;
			link_q  <= LK_IDLE;
			pbe_q   <= LK_IDLE;
			proto_q <= 8'd0;
			cnt_q   <= 8'd0;
			exp_q   <= 8'd0;
			rcrc_q  <= 16'h0000;
			crc_q   <= 16'h0000;
		end else if (byte_valid) begin
			rx_q    <= rx_d;
			link_q  <= link_d;
			pbe_q   <= pbe_d;
			proto_q <= proto_d;
			cnt_q   <= cnt_d;
			exp_q   <= exp_d;
			rcrc_q  <= rcrc_d;
			crc_q   <= crc_d;
		end
	end

endmodule

// ===== hdl/hfr_queue.sv =====
// Short result queue between the deframer and the output stage.
// Depends on hfr_pkg.
module hfr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hfr_pkg::result_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output hfr_pkg::result_t pop_data
);
	import hfr_pkg::*;

	result_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push, do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/hfr_back.sv =====
// Output stage: registers one result word and drives the result stream.
// Depends on hfr_pkg.
module hfr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  hfr_pkg::result_t q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output hfr_pkg::result_t out_data
);
	import hfr_pkg::*;

	logic    valid_q;
	result_t data_q;

	// refill when the register is empty or its word leaves this cycle
	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) data_q <= q_data;
	end

endmodule

// ===== hdl/hdlc_frame_receiver_crc16.sv =====
// Top level of the HDLC frame receiver: configuration registers, deframer,
// result queue and output stage. Depends on hfr_pkg, hfr_front, hfr_queue, hfr_back.
//
// Usage:
//   s_axis carries one line byte per word (tdata[7:0]). Every word is consumed;
//   most produce one result word on m_axis, flags outside a frame, protocol
//   bytes, escapes, CRC bytes and bytes while hunting produce none.
//   m_axis tuser holds the event code (header byte, payload byte, CRC ok,
//   CRC fail, raw frame end); tdata holds value, position, payload count,
//   received CRC and computed CRC.
//   cfg writes set flag, escape, protocol ids, raw length and length offset;
//   cfg_ready is always high. Write only while no frame words are in flight.
// Timing:
//   One byte per cycle while s_axis_tready is high; the deframer updates state
//   and the CRC for a byte in the cycle it is taken. A result reaches m_axis
//   through the queue memory, then the output register.
//   A four-word queue sits between deframer and output register; s_axis_tready
//   drops only when that queue is full because m_axis has been stalled.
// Reset:
//   arst_n clears all control state, reloads the register defaults and puts
//   the deframer in the wait state, which accepts a frame start without flag.
module hdlc_frame_receiver_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] value, [15:8] position,
	                                    // [23:16] payload_count,
	                                    // [39:24] crc_from_line, [55:40] crc_worked_out
	output logic [2:0]  m_axis_tuser,   // [2:0] event_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import hfr_pkg::*;

	cfg_t    cfg_q;
	logic    q_full, q_empty, q_pop, byte_valid, res_valid, out_valid;
	result_t res, q_data, out_data;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign byte_valid    = s_axis_tvalid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value          <= 8'h7E;
			cfg_q.escape_value        <= 8'h7D;
			cfg_q.message_protocol_id <= 8'h00;
			cfg_q.raw_protocol_id     <= 8'h01;
			cfg_q.raw_max_length      <= 8'd128;
			cfg_q.length_field_offset <= 3'd7;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FLAG:       cfg_q.flag_value          <= cfg_data;
				CFG_ESCAPE:     cfg_q.escape_value        <= cfg_data;
				CFG_MSG_ID:     cfg_q.message_protocol_id <= cfg_data;
				CFG_RAW_ID:     cfg_q.raw_protocol_id     <= cfg_data;
				CFG_RAW_MAX:    cfg_q.raw_max_length      <= cfg_data;
				CFG_LEN_OFFSET: cfg_q.length_field_offset <= cfg_data[2:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	hfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (byte_valid),
		.rx_byte    (s_axis_tdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	hfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_data)
	);

	hfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tuser  = out_data.event_res;
	assign m_axis_tdata  = {out_data.crc_worked_out, out_data.crc_from_line,
		out_data.payload_count, out_data.position, out_data.value};

endmodule
